@@ hdl/svpwm_duty_generator_assert.svh @@
// Assertion macros for the space vector PWM duty generator.
// Used by the top level; relies on signals named clock and reset in scope.
`ifndef SVPWM_DUTY_GENERATOR_ASSERT_SVH
`define SVPWM_DUTY_GENERATOR_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define SVPWM_ASSERT_NOW(label, cond, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (prop)) \
      else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define SVPWM_ASSERT_NEXT(label, cond, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) \
      else $error(msg);

`endif

@@ hdl/svpwm_pkg.sv @@
// Shared types, constants and the sine table generator for the duty generator.
// No dependencies; used by the channel interfaces and the top level.
package svpwm_pkg;

   // Field widths of the channels.
   localparam int ANGLE_W = 16;
   localparam int VOLT_W  = 16;
   localparam int DUTY_W  = 16;
   localparam int SEC_W   = 3;

   // Configuration port.
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 18;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ZERO_OFFSET = 3'd0,
      CSR_POLE_PAIRS  = 3'd1,
      CSR_REVERSE_DIR = 3'd2,
      CSR_TIME_GAIN   = 3'd3,
      CSR_MAX_DUTY    = 3'd4
   } csr_index_type;

   localparam logic [15:0] RST_ZERO_OFFSET = 16'd0;
   localparam logic [6:0]  RST_POLE_PAIRS  = 7'd7;
   localparam logic        RST_REVERSE_DIR = 1'b0;
   localparam logic [17:0] RST_TIME_GAIN   = 18'd113512;
   localparam logic [15:0] RST_MAX_DUTY    = 16'd100;

   // Sectors of the hexagon; zero marks an undetermined sector.
   typedef enum logic [SEC_W-1:0] {
      SEC_NONE = 3'd0,
      SEC_1    = 3'd1,
      SEC_2    = 3'd2,
      SEC_3    = 3'd3,
      SEC_4    = 3'd4,
      SEC_5    = 3'd5,
      SEC_6    = 3'd6
   } sector_type;

   // Sign pattern {n3>0, n2>0, beta>0} to sector.
   localparam sector_type PATTERN_TO_SECTOR [8] = '{SEC_NONE, SEC_2, SEC_6, SEC_1,
                                                   SEC_4, SEC_3, SEC_5, SEC_NONE};

   // Fixed-point constants: one period is 2^16, sqrt(3) in Q16.
   localparam logic [16:0]        ONE_T     = 17'd65536;
   localparam logic [16:0]        HALF_T    = 17'd32768;
   localparam logic signed [17:0] SQRT3_Q16 = 18'sd113512;

   // Quarter-wave sine polynomial coefficients in Q16.
   localparam longint PA1 = 102944;
   localparam longint PA3 = 42047;
   localparam longint PA5 = 4640;

   // Quarter-wave sine entry in Q0.15, evaluated when the table is built.
   function automatic logic [14:0] quarter_sine(input int unsigned idx,
                                                input int unsigned tbits);
      longint z;
      longint z2;
      longint p;
      longint s;
      z  = longint'(idx) << (18 - tbits);
      z2 = (z * z) >>> 16;
      p  = PA3 - ((z2 * PA5) >>> 16);
      p  = PA1 - ((z2 * p) >>> 16);
      s  = (z * p) >>> 16;
      if (s > 65536) s = 65536;
      if (s < 0) s = 0;
      s = (s + 1) >>> 1;
      if (s > 32767) s = 32767;
      return s[14:0];
   endfunction

endpackage

@@ hdl/svpwm_req_if.sv @@
// Request channel: one beat carries a shaft angle and the q/d voltage commands.
// Depends on svpwm_pkg for field widths.
interface svpwm_req_if;
   logic                                  valid;
   logic                                  ready;
   logic [svpwm_pkg::ANGLE_W-1:0]         mech_angle;
   logic signed [svpwm_pkg::VOLT_W-1:0]   volt_q;
   logic signed [svpwm_pkg::VOLT_W-1:0]   volt_d;

   modport source (output valid, mech_angle, volt_q, volt_d, input ready);
   modport sink   (input valid, mech_angle, volt_q, volt_d, output ready);
endinterface

@@ hdl/svpwm_rsp_if.sv @@
// Response channel: one beat carries three phase duties and the sector.
// Depends on svpwm_pkg for field widths.
interface svpwm_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [svpwm_pkg::DUTY_W-1:0]      duty_u;
   logic [svpwm_pkg::DUTY_W-1:0]      duty_v;
   logic [svpwm_pkg::DUTY_W-1:0]      duty_w;
   logic [svpwm_pkg::SEC_W-1:0]       sector;

   modport source (output valid, duty_u, duty_v, duty_w, sector, input ready);
   modport sink   (input valid, duty_u, duty_v, duty_w, sector, output ready);
endinterface

@@ hdl/svpwm_duty_generator.sv @@
// Channel   | Dir | Beat contents
// req_ch    | in  | mech_angle, volt_q, volt_d
// rsp_ch    | out | duty_u, duty_v, duty_w, sector
// csr_*     | in  | write enable, register index, write data
//
// One beat enters per cycle unless a held response stalls the pipeline; each result
// passes 12 arithmetic stages plus 17 stages of the restoring divider for overruns.
// Reset is synchronous and clears the valid chain and the configuration.
// A held response freezes the whole pipeline; nothing is dropped or repeated.
// Depends on svpwm_pkg, svpwm_req_if, svpwm_rsp_if and the assertion header.
module svpwm_duty_generator #(
   parameter int ANGLE_BITS      = 16,
   parameter int SINE_TABLE_BITS = 10
) (
   input  logic                                    clock,
   input  logic                                    reset,
   svpwm_req_if.sink                               req_ch,
   svpwm_rsp_if.source                             rsp_ch,
   input  logic                                    csr_we,
   input  logic [svpwm_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [svpwm_pkg::CSR_DATA_W-1:0]        csr_wdata
);

   localparam int TB       = SINE_TABLE_BITS;
   localparam int QUARTER  = 1 << (TB - 2);
   localparam int T_W      = 21;
   localparam int S_W      = T_W + 1;
   localparam int REM_W    = S_W + 1;
   localparam int Q_W      = 17;
   localparam int NSTAGE   = 12 + Q_W;
   localparam logic [TB-2:0] QTR_IDX = (TB-1)'(QUARTER);

   // Configuration registers.
   logic [15:0] zero_offset_ff;
   logic [6:0]  pole_pairs_ff;
   logic        reverse_dir_ff;
   logic [17:0] time_gain_ff;
   logic [15:0] max_duty_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         zero_offset_ff <= svpwm_pkg::RST_ZERO_OFFSET;
         pole_pairs_ff  <= svpwm_pkg::RST_POLE_PAIRS;
         reverse_dir_ff <= svpwm_pkg::RST_REVERSE_DIR;
         time_gain_ff   <= svpwm_pkg::RST_TIME_GAIN;
         max_duty_ff    <= svpwm_pkg::RST_MAX_DUTY;
      end else if (csr_we) begin
         unique case (csr_index)
            svpwm_pkg::CSR_ZERO_OFFSET: zero_offset_ff <= csr_wdata[15:0];
            svpwm_pkg::CSR_POLE_PAIRS:  pole_pairs_ff  <= csr_wdata[6:0];
            svpwm_pkg::CSR_REVERSE_DIR: reverse_dir_ff <= csr_wdata[0];
            svpwm_pkg::CSR_TIME_GAIN:   time_gain_ff   <= csr_wdata[17:0];
            svpwm_pkg::CSR_MAX_DUTY:    max_duty_ff    <= csr_wdata[15:0];
            default: begin
            end
         endcase
      end
   end

   // Global advance: the pipeline moves unless a finished beat is held.
   logic              adv;
   logic [NSTAGE-1:0] vld_ff;

   assign adv          = !vld_ff[NSTAGE-1] || rsp_ch.ready;
   assign req_ch.ready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[NSTAGE-2:0], req_ch.valid};
      end
   end

   // Stage 1: electrical angle and table index.
   logic [ANGLE_BITS-1:0]   sa_ang;
   logic [ANGLE_BITS-1:0]   off_ang;
   logic [ANGLE_BITS-1:0]   diff_ang;
   logic [ANGLE_BITS+6:0]   scaled_ang;
   logic [ANGLE_BITS-1:0]   elec_in;
   logic [TB-1:0]           idx_in;
   logic [TB-1:0]           s1_idx_ff;
   logic signed [15:0]      s1_vq_ff;
   logic signed [15:0]      s1_vd_ff;

   assign sa_ang     = ANGLE_BITS'(req_ch.mech_angle);
   assign off_ang    = ANGLE_BITS'(zero_offset_ff);
   assign diff_ang   = sa_ang - off_ang;
   assign scaled_ang = (ANGLE_BITS+7)'(diff_ang) * (ANGLE_BITS+7)'(pole_pairs_ff);
   assign elec_in    = reverse_dir_ff ? (~scaled_ang[ANGLE_BITS-1:0] + ANGLE_BITS'(1))
                                      : scaled_ang[ANGLE_BITS-1:0];

   if (ANGLE_BITS >= TB) begin : g_idx_shr
      assign idx_in = elec_in[ANGLE_BITS-1 -: TB];
   end else begin : g_idx_shl
      assign idx_in = {elec_in, {(TB-ANGLE_BITS){1'b0}}};
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_idx_ff <= idx_in;
         s1_vq_ff  <= req_ch.volt_q;
         s1_vd_ff  <= req_ch.volt_d;
      end
   end

   // Quarter-wave sine table, built at elaboration.
   logic [14:0] qsin_tab [QUARTER+1];

   for (genvar g = 0; g <= QUARTER; g++) begin : g_tab
      localparam logic [14:0] ENTRY = svpwm_pkg::quarter_sine(g, TB);
      assign qsin_tab[g] = ENTRY;
   end

   // Stage 2: sine and cosine by quadrant symmetry.
   logic [1:0]         quad;
   logic [TB-2:0]      ra_idx;
   logic [TB-2:0]      rb_idx;
   logic signed [15:0] pos_a;
   logic signed [15:0] pos_b;
   logic signed [15:0] sn_in;
   logic signed [15:0] cs_in;
   logic signed [15:0] s2_sn_ff;
   logic signed [15:0] s2_cs_ff;
   logic signed [15:0] s2_vq_ff;
   logic signed [15:0] s2_vd_ff;

   assign quad   = s1_idx_ff[TB-1 -: 2];
   assign ra_idx = {1'b0, s1_idx_ff[TB-3:0]};
   assign rb_idx = QTR_IDX - ra_idx;
   assign pos_a  = $signed({1'b0, qsin_tab[ra_idx]});
   assign pos_b  = $signed({1'b0, qsin_tab[rb_idx]});

   always_comb begin
      unique case (quad)
         2'd0: begin sn_in = pos_a;  cs_in = pos_b;  end
         2'd1: begin sn_in = pos_b;  cs_in = -pos_a; end
         2'd2: begin sn_in = -pos_a; cs_in = -pos_b; end
         default: begin sn_in = -pos_b; cs_in = pos_a; end
      endcase
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_sn_ff <= sn_in;
         s2_cs_ff <= cs_in;
         s2_vq_ff <= s1_vq_ff;
         s2_vd_ff <= s1_vd_ff;
      end
   end

   // Stage 3: the four inverse Park products.
   logic signed [31:0] s3_dc_ff;
   logic signed [31:0] s3_qs_ff;
   logic signed [31:0] s3_ds_ff;
   logic signed [31:0] s3_qc_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         s3_dc_ff <= s2_vd_ff * s2_cs_ff;
         s3_qs_ff <= s2_vq_ff * s2_sn_ff;
         s3_ds_ff <= s2_vd_ff * s2_sn_ff;
         s3_qc_ff <= s2_vq_ff * s2_cs_ff;
      end
   end

   // Stage 4: alpha and beta in Q3.30.
   logic signed [32:0] s4_alpha_ff;
   logic signed [32:0] s4_beta_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         s4_alpha_ff <= 33'(s3_dc_ff) - 33'(s3_qs_ff);
         s4_beta_ff  <= 33'(s3_ds_ff) + 33'(s3_qc_ff);
      end
   end

   // Stage 5: sqrt(3) times alpha.
   logic signed [50:0] s5_prod_ff;
   logic signed [32:0] s5_beta_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         s5_prod_ff <= 51'(svpwm_pkg::SQRT3_Q16) * 51'(s4_alpha_ff);
         s5_beta_ff <= s4_beta_ff;
      end
   end

   // Stage 6: the two projection numerators.
   logic signed [51:0] beta_sh;
   logic signed [51:0] s6_n2_ff;
   logic signed [51:0] s6_n3_ff;
   logic signed [32:0] s6_beta_ff;

   assign beta_sh = 52'(s5_beta_ff) <<< 16;

   always_ff @(posedge clock) begin
      if (adv) begin
         s6_n2_ff   <= 52'(s5_prod_ff) - beta_sh;
         s6_n3_ff   <= -52'(s5_prod_ff) - beta_sh;
         s6_beta_ff <= s5_beta_ff;
      end
   end

   // Stage 7: sector and the magnitudes that set the two active times.
   logic [2:0]                pat;
   svpwm_pkg::sector_type     sec_in;
   logic signed [34:0]        v1;
   logic signed [34:0]        v2;
   logic signed [34:0]        v3;
   logic signed [34:0]        m1_sel;
   logic signed [34:0]        m2_sel;
   logic [33:0]               s7_m1_ff;
   logic [33:0]               s7_m2_ff;
   svpwm_pkg::sector_type     s7_sec_ff;

   assign pat    = {s6_n3_ff > 52'sd0, s6_n2_ff > 52'sd0, s6_beta_ff > 33'sd0};
   assign sec_in = svpwm_pkg::PATTERN_TO_SECTOR[pat];
   assign v1     = 35'(s6_beta_ff);
   assign v2     = s6_n2_ff[51:17];
   assign v3     = s6_n3_ff[51:17];

   always_comb begin
      unique case (sec_in)
         svpwm_pkg::SEC_1: begin m1_sel = v2;  m2_sel = v1;  end
         svpwm_pkg::SEC_2: begin m1_sel = -v3; m2_sel = -v2; end
         svpwm_pkg::SEC_3: begin m1_sel = v1;  m2_sel = v3;  end
         svpwm_pkg::SEC_4: begin m1_sel = -v2; m2_sel = -v1; end
         svpwm_pkg::SEC_5: begin m1_sel = v3;  m2_sel = v2;  end
         svpwm_pkg::SEC_6: begin m1_sel = -v1; m2_sel = -v3; end
         default: begin m1_sel = '0; m2_sel = '0; end
      endcase
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s7_m1_ff  <= m1_sel[33:0];
         s7_m2_ff  <= m2_sel[33:0];
         s7_sec_ff <= sec_in;
      end
   end

   // Stage 8: time gain products.
   logic [51:0]           s8_p1_ff;
   logic [51:0]           s8_p2_ff;
   svpwm_pkg::sector_type s8_sec_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         s8_p1_ff  <= 52'(time_gain_ff) * 52'(s7_m1_ff);
         s8_p2_ff  <= 52'(time_gain_ff) * 52'(s7_m2_ff);
         s8_sec_ff <= s7_sec_ff;
      end
   end

   // Stage 9: active times, their sum and the overrun flag.
   logic [T_W-1:0]        t1_in;
   logic [T_W-1:0]        t2_in;
   logic [S_W-1:0]        sum_in;
   logic [T_W-1:0]        s9_t1_ff;
   logic [T_W-1:0]        s9_t2_ff;
   logic [S_W-1:0]        s9_sum_ff;
   logic                  s9_over_ff;
   svpwm_pkg::sector_type s9_sec_ff;

   assign t1_in  = s8_p1_ff[30 +: T_W];
   assign t2_in  = s8_p2_ff[30 +: T_W];
   assign sum_in = S_W'(t1_in) + S_W'(t2_in);

   always_ff @(posedge clock) begin
      if (adv) begin
         s9_t1_ff   <= t1_in;
         s9_t2_ff   <= t2_in;
         s9_sum_ff  <= sum_in;
         s9_over_ff <= sum_in > S_W'(svpwm_pkg::ONE_T);
         s9_sec_ff  <= s8_sec_ff;
      end
   end

   // Restoring divider, one quotient bit per stage: q = t * 2^16 / sum.
   logic [REM_W-1:0]      dv_rem1_ff [Q_W];
   logic [REM_W-1:0]      dv_rem2_ff [Q_W];
   logic [Q_W-1:0]        dv_q1_ff   [Q_W];
   logic [Q_W-1:0]        dv_q2_ff   [Q_W];
   logic [S_W-1:0]        dv_den_ff  [Q_W];
   logic [T_W-1:0]        dv_t1_ff   [Q_W];
   logic [T_W-1:0]        dv_t2_ff   [Q_W];
   logic                  dv_over_ff [Q_W];
   svpwm_pkg::sector_type dv_sec_ff  [Q_W];

   for (genvar j = 0; j < Q_W; j++) begin : g_div
      logic [REM_W-1:0]      x1;
      logic [REM_W-1:0]      x2;
      logic [Q_W-1:0]        q1p;
      logic [Q_W-1:0]        q2p;
      logic [S_W-1:0]        den;
      logic [T_W-1:0]        t1p;
      logic [T_W-1:0]        t2p;
      logic                  overp;
      svpwm_pkg::sector_type secp;
      logic                  ge1;
      logic                  ge2;

      if (j == 0) begin : g_first
         assign x1    = REM_W'(s9_t1_ff);
         assign x2    = REM_W'(s9_t2_ff);
         assign q1p   = '0;
         assign q2p   = '0;
         assign den   = s9_sum_ff;
         assign t1p   = s9_t1_ff;
         assign t2p   = s9_t2_ff;
         assign overp = s9_over_ff;
         assign secp  = s9_sec_ff;
      end else begin : g_next
         assign x1    = {dv_rem1_ff[j-1][REM_W-2:0], 1'b0};
         assign x2    = {dv_rem2_ff[j-1][REM_W-2:0], 1'b0};
         assign q1p   = dv_q1_ff[j-1];
         assign q2p   = dv_q2_ff[j-1];
         assign den   = dv_den_ff[j-1];
         assign t1p   = dv_t1_ff[j-1];
         assign t2p   = dv_t2_ff[j-1];
         assign overp = dv_over_ff[j-1];
         assign secp  = dv_sec_ff[j-1];
      end

      assign ge1 = x1 >= REM_W'(den);
      assign ge2 = x2 >= REM_W'(den);

      always_ff @(posedge clock) begin
         if (adv) begin
            dv_rem1_ff[j] <= ge1 ? (x1 - REM_W'(den)) : x1;
            dv_rem2_ff[j] <= ge2 ? (x2 - REM_W'(den)) : x2;
            dv_q1_ff[j]   <= {q1p[Q_W-2:0], ge1};
            dv_q2_ff[j]   <= {q2p[Q_W-2:0], ge2};
            dv_den_ff[j]  <= den;
            dv_t1_ff[j]   <= t1p;
            dv_t2_ff[j]   <= t2p;
            dv_over_ff[j] <= overp;
            dv_sec_ff[j]  <= secp;
         end
      end
   end

   // Post stage 1: centered zero vector and phase times.
   logic [16:0]           t1s;
   logic [16:0]           t2s;
   logic [16:0]           t0;
   logic [16:0]           hz;
   logic [16:0]           ta_in;
   logic [16:0]           tb_in;
   logic [16:0]           tc_in;
   logic [16:0]           p1_ta_ff;
   logic [16:0]           p1_tb_ff;
   logic [16:0]           p1_tc_ff;
   svpwm_pkg::sector_type p1_sec_ff;
   svpwm_pkg::sector_type dsec;

   assign dsec = dv_sec_ff[Q_W-1];
   assign t1s  = dv_over_ff[Q_W-1] ? dv_q1_ff[Q_W-1] : dv_t1_ff[Q_W-1][16:0];
   assign t2s  = dv_over_ff[Q_W-1] ? dv_q2_ff[Q_W-1] : dv_t2_ff[Q_W-1][16:0];
   assign t0   = dv_over_ff[Q_W-1] ? 17'd0 : (svpwm_pkg::ONE_T - t1s - t2s);
   assign hz   = t0 >> 1;

   always_comb begin
      unique case (dsec)
         svpwm_pkg::SEC_1: begin
            ta_in = t1s + t2s + hz; tb_in = t2s + hz;       tc_in = hz;
         end
         svpwm_pkg::SEC_2: begin
            ta_in = t1s + hz;       tb_in = t1s + t2s + hz; tc_in = hz;
         end
         svpwm_pkg::SEC_3: begin
            ta_in = hz;             tb_in = t1s + t2s + hz; tc_in = t2s + hz;
         end
         svpwm_pkg::SEC_4: begin
            ta_in = hz;             tb_in = t1s + hz;       tc_in = t1s + t2s + hz;
         end
         svpwm_pkg::SEC_5: begin
            ta_in = t2s + hz;       tb_in = hz;             tc_in = t1s + t2s + hz;
         end
         svpwm_pkg::SEC_6: begin
            ta_in = t1s + t2s + hz; tb_in = hz;             tc_in = t1s + hz;
         end
         default: begin
            ta_in = svpwm_pkg::HALF_T;
            tb_in = svpwm_pkg::HALF_T;
            tc_in = svpwm_pkg::HALF_T;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p1_ta_ff  <= ta_in;
         p1_tb_ff  <= tb_in;
         p1_tc_ff  <= tc_in;
         p1_sec_ff <= dsec;
      end
   end

   // Post stage 2: scale phase times to the duty range.
   logic [32:0]           p2_da_ff;
   logic [32:0]           p2_db_ff;
   logic [32:0]           p2_dc_ff;
   svpwm_pkg::sector_type p2_sec_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         p2_da_ff  <= 33'(p1_ta_ff) * 33'(max_duty_ff);
         p2_db_ff  <= 33'(p1_tb_ff) * 33'(max_duty_ff);
         p2_dc_ff  <= 33'(p1_tc_ff) * 33'(max_duty_ff);
         p2_sec_ff <= p1_sec_ff;
      end
   end

   // Output register: truncate and clamp to the full-scale duty.
   logic [15:0]           out_u_ff;
   logic [15:0]           out_v_ff;
   logic [15:0]           out_w_ff;
   svpwm_pkg::sector_type out_sec_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         out_u_ff   <= (p2_da_ff[32:16] > 17'(max_duty_ff)) ? max_duty_ff : p2_da_ff[31:16];
         out_v_ff   <= (p2_db_ff[32:16] > 17'(max_duty_ff)) ? max_duty_ff : p2_db_ff[31:16];
         out_w_ff   <= (p2_dc_ff[32:16] > 17'(max_duty_ff)) ? max_duty_ff : p2_dc_ff[31:16];
         out_sec_ff <= p2_sec_ff;
      end
   end

   assign rsp_ch.valid  = vld_ff[NSTAGE-1];
   assign rsp_ch.duty_u = out_u_ff;
   assign rsp_ch.duty_v = out_v_ff;
   assign rsp_ch.duty_w = out_w_ff;
   assign rsp_ch.sector = out_sec_ff;

   // Checks on the pipeline and on the result beat.
   logic                   duties_in_range;
   logic                   duties_equal;
   logic                   no_sector_beat;
   logic [NSTAGE+18:0]     held_state;

   assign duties_in_range = (out_u_ff <= max_duty_ff) && (out_v_ff <= max_duty_ff) &&
                            (out_w_ff <= max_duty_ff);
   assign duties_equal    = (out_u_ff == out_v_ff) && (out_v_ff == out_w_ff);
   assign no_sector_beat  = rsp_ch.valid && (out_sec_ff == svpwm_pkg::SEC_NONE);
   assign held_state      = {vld_ff, out_u_ff, out_sec_ff};

   `include "svpwm_duty_generator_assert.svh"

   `SVPWM_ASSERT_NOW(a_duty_clamped, rsp_ch.valid, duties_in_range, "duty above full scale")
   `SVPWM_ASSERT_NOW(a_no_sector_half, no_sector_beat, duties_equal, "sector zero, duties differ")
   `SVPWM_ASSERT_NEXT(a_stall_freezes, !adv, $stable(held_state), "pipeline moved during a stall")

endmodule

@@ sim/svpwm_checker.sv @@
// Checker for the space vector PWM duty generator: watches both channels,
// predicts each result from the request beat and the shadow configuration.
// Depends on svpwm_pkg and the channel interfaces.
module svpwm_checker (
   input  logic                                clock,
   input  logic                                reset,
   svpwm_req_if                                req_ch,
   svpwm_rsp_if                                rsp_ch,
   input  logic                                csr_we,
   input  logic [svpwm_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [svpwm_pkg::CSR_DATA_W-1:0]    csr_wdata,
   output int                                  fail_count,
   output int                                  pending_duties
);

   typedef struct packed {
      logic [15:0] duty_u;
      logic [15:0] duty_v;
      logic [15:0] duty_w;
      logic [2:0]  sector;
   } duty_set_type;

   localparam int TBITS = 10;

   duty_set_type expected_duties [$];
   logic [15:0] offset_q;
   logic [6:0]  pairs_q;
   logic        reversed_q;
   logic [17:0] gain_q;
   logic [15:0] full_duty_q;

   function automatic longint fl_shr(longint x, int n);
      return x >>> n;
   endfunction

   function automatic longint quarter_wave(int unsigned i);
      longint z, z2, p, s;
      z  = longint'(i) << (18 - TBITS);
      z2 = (z * z) >>> 16;
      p  = 42047 - ((z2 * 4640) >>> 16);
      p  = 102944 - ((z2 * p) >>> 16);
      s  = (z * p) >>> 16;
      if (s > 65536) s = 65536;
      if (s < 0) s = 0;
      s = (s + 1) >>> 1;
      return (s > 32767) ? 32767 : s;
   endfunction

   function automatic longint wave_sine(int unsigned k);
      int unsigned quart, quad, r;
      quart = 1 << (TBITS - 2);
      k     = k & ((1 << TBITS) - 1);
      quad  = k >> (TBITS - 2);
      r     = k & (quart - 1);
      case (quad)
         0: return quarter_wave(r);
         1: return quarter_wave(quart - r);
         2: return -quarter_wave(r);
         default: return -quarter_wave(quart - r);
      endcase
   endfunction

   function automatic longint vec_to_time(longint v);
      return (longint'(gain_q) * v) >>> 30;
   endfunction

   function automatic logic [15:0] time_to_duty(longint t);
      longint d;
      if (t < 0) t = 0;
      d = (t * longint'(full_duty_q)) >>> 16;
      return (d > full_duty_q) ? full_duty_q : d[15:0];
   endfunction

   // Computes the three phase duties and the sector of one request beat.
   function automatic duty_set_type predict_duties(logic [15:0] angle,
                                                   logic signed [15:0] vq,
                                                   logic signed [15:0] vd);
      logic [15:0] elec;
      logic [31:0] prod;
      longint sn, cs, alpha, beta, n2, n3, v1, v2, v3;
      longint t1, t2, t0, h, ta, tb, tc, total;
      logic [2:0] pattern;
      svpwm_pkg::sector_type sec;
      duty_set_type res;
      elec = angle - offset_q;
      prod = elec * pairs_q;
      elec = prod[15:0];
      if (reversed_q) elec = -elec;
      sn = wave_sine(elec >> 6);
      cs = wave_sine((elec >> 6) + (1 << (TBITS - 2)));
      alpha = longint'(vd) * cs - longint'(vq) * sn;
      beta  = longint'(vd) * sn + longint'(vq) * cs;
      n2 = 113512 * alpha - beta * 65536;
      n3 = -113512 * alpha - beta * 65536;
      v1 = beta;
      v2 = fl_shr(n2, 17);
      v3 = fl_shr(n3, 17);
      pattern = {n3 > 0, n2 > 0, beta > 0};
      sec = svpwm_pkg::PATTERN_TO_SECTOR[pattern];
      t1 = 0;
      t2 = 0;
      case (sec)
         svpwm_pkg::SEC_1: begin t2 = vec_to_time(v1);  t1 = vec_to_time(v2);  end
         svpwm_pkg::SEC_2: begin t2 = vec_to_time(-v2); t1 = vec_to_time(-v3); end
         svpwm_pkg::SEC_3: begin t1 = vec_to_time(v1);  t2 = vec_to_time(v3);  end
         svpwm_pkg::SEC_4: begin t2 = vec_to_time(-v1); t1 = vec_to_time(-v2); end
         svpwm_pkg::SEC_5: begin t2 = vec_to_time(v2);  t1 = vec_to_time(v3);  end
         svpwm_pkg::SEC_6: begin t1 = vec_to_time(-v1); t2 = vec_to_time(-v3); end
         default: ;
      endcase
      // Overrun: scale both active times to fill the period.
      if (t1 + t2 > 65536) begin
         total = t1 + t2;
         t1 = t1 * 65536 / total;
         t2 = t2 * 65536 / total;
         t0 = 0;
      end else begin
         t0 = 65536 - t1 - t2;
      end
      h = t0 >>> 1;
      case (sec)
         svpwm_pkg::SEC_1: begin ta = t1 + t2 + h; tb = t2 + h; tc = h; end
         svpwm_pkg::SEC_2: begin ta = t1 + h; tb = t1 + t2 + h; tc = h; end
         svpwm_pkg::SEC_3: begin ta = h; tb = t1 + t2 + h; tc = t2 + h; end
         svpwm_pkg::SEC_4: begin ta = h; tb = t1 + h; tc = t1 + t2 + h; end
         svpwm_pkg::SEC_5: begin ta = t2 + h; tb = h; tc = t1 + t2 + h; end
         svpwm_pkg::SEC_6: begin ta = t1 + t2 + h; tb = h; tc = t1 + h; end
         default: begin ta = 32768; tb = 32768; tc = 32768; end
      endcase
      res.duty_u = time_to_duty(ta);
      res.duty_v = time_to_duty(tb);
      res.duty_w = time_to_duty(tc);
      res.sector = sec;
      return res;
   endfunction

   // Shadow registers, queueing of predictions and comparison of results.
   always @(posedge clock) begin
      duty_set_type want;
      duty_set_type got;
      if (reset) begin
         offset_q       <= svpwm_pkg::RST_ZERO_OFFSET;
         pairs_q        <= svpwm_pkg::RST_POLE_PAIRS;
         reversed_q     <= svpwm_pkg::RST_REVERSE_DIR;
         gain_q         <= svpwm_pkg::RST_TIME_GAIN;
         full_duty_q    <= svpwm_pkg::RST_MAX_DUTY;
         fail_count     <= 0;
         pending_duties <= 0;
         expected_duties.delete();
      end else begin
         if (req_ch.valid && req_ch.ready)
            expected_duties.push_back(predict_duties(req_ch.mech_angle,
                                                     req_ch.volt_q, req_ch.volt_d));
         if (rsp_ch.valid && rsp_ch.ready) begin
            got = {rsp_ch.duty_u, rsp_ch.duty_v, rsp_ch.duty_w, rsp_ch.sector};
            if (expected_duties.size() == 0) begin
               if (fail_count < 10)
                  $display("ERROR: unexpected result beat %h", got);
               fail_count <= fail_count + 1;
            end else begin
               want = expected_duties.pop_front();
               if (want != got) begin
                  if (fail_count < 10)
                     $display("ERROR: expected u=%0d v=%0d w=%0d sec=%0d, got u=%0d v=%0d w=%0d sec=%0d",
                              want.duty_u, want.duty_v, want.duty_w, want.sector,
                              got.duty_u, got.duty_v, got.duty_w, got.sector);
                  fail_count <= fail_count + 1;
               end
            end
         end
         pending_duties <= expected_duties.size();
         if (csr_we) begin
            case (csr_index)
               svpwm_pkg::CSR_ZERO_OFFSET: offset_q    <= csr_wdata[15:0];
               svpwm_pkg::CSR_POLE_PAIRS:  pairs_q     <= csr_wdata[6:0];
               svpwm_pkg::CSR_REVERSE_DIR: reversed_q  <= csr_wdata[0];
               svpwm_pkg::CSR_TIME_GAIN:   gain_q      <= csr_wdata;
               svpwm_pkg::CSR_MAX_DUTY:    full_duty_q <= csr_wdata[15:0];
               default: ;
            endcase
         end
      end
   end
endmodule

@@ sim/testbench.sv @@
// Top of the duty generator testbench: clock, reset, configuration phases,
// request stimulus, response stalls and the verdict. Depends on svpwm_pkg,
// the channel interfaces, the DUT and svpwm_checker.
module testbench;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [svpwm_pkg::CSR_IDX_W-1:0]  csr_index = '0;
   logic [svpwm_pkg::CSR_DATA_W-1:0] csr_wdata = '0;
   int fail_count;
   int pending_duties;
   int cycle_count = 0;

   svpwm_req_if req_ch ();
   svpwm_rsp_if rsp_ch ();

   svpwm_duty_generator i_dut (
      .clock(clock), .reset(reset), .req_ch(req_ch), .rsp_ch(rsp_ch),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata));

   svpwm_checker i_checker (
      .clock(clock), .reset(reset), .req_ch(req_ch), .rsp_ch(rsp_ch),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .fail_count(fail_count), .pending_duties(pending_duties));

   always #2 clock = ~clock;

   // Run limit well above the slowest legal run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 400000) begin
         $display("Verification failed");
         $finish;
      end
   end

   // Result side stalls for a random gap before each beat, unless quiet_rsp is set.
   logic quiet_rsp = 1'b0;
   initial begin
      int gap;
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_ch.valid && rsp_ch.ready) begin
            gap = quiet_rsp ? 0 : $urandom_range(0, 6);
            if (gap > 0) begin
               rsp_ch.ready <= 1'b0;
               repeat (gap) @(posedge clock);
            end
            rsp_ch.ready <= 1'b1;
         end else if (!rsp_ch.ready) begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // Drives one register write; the caller drops the write enable afterwards.
   task automatic write_reg(svpwm_pkg::csr_index_type idx,
                            logic [svpwm_pkg::CSR_DATA_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   // Sends one request beat, after a random gap unless no_gap is set.
   task automatic send_beat(logic [15:0] angle, logic [15:0] vq, logic [15:0] vd,
                            bit no_gap);
      int gap;
      gap = no_gap ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.mech_angle <= angle;
      req_ch.volt_q     <= vq;
      req_ch.volt_d     <= vd;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   // Waits until every accepted beat has come back, then idles a little.
   task automatic settle();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (pending_duties != 0);
      repeat (40) @(posedge clock);
   endtask

   task automatic random_volts(output logic [15:0] vq, output logic [15:0] vd);
      case ($urandom_range(0, 3))
         0: begin vq = 16'($urandom); vd = 16'($urandom); end
         1: begin
            vq = 16'($urandom_range(0, 8000) - 4000);
            vd = 16'($urandom_range(0, 8000) - 4000);
         end
         2: begin vq = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000; vd = 16'($urandom); end
         default: begin vq = 16'($urandom_range(0, 40000) - 20000); vd = '0; end
      endcase
   endtask

   initial begin
      logic [15:0] vq, vd;
      bit burst;
      req_ch.valid      = 1'b0;
      req_ch.mech_angle = '0;
      req_ch.volt_q     = '0;
      req_ch.volt_d     = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed beats: field extremes, zero vector and axis points.
      send_beat(16'h0000, 16'h0000, 16'h0000, 1'b0);
      send_beat(16'hFFFF, 16'h7FFF, 16'h7FFF, 1'b0);
      send_beat(16'h0000, 16'h8000, 16'h8000, 1'b0);
      send_beat(16'h8000, 16'h7FFF, 16'h8000, 1'b0);
      send_beat(16'h4000, 16'h8000, 16'h7FFF, 1'b0);
      send_beat(16'h0000, 16'h0000, 16'h4000, 1'b0);
      send_beat(16'h0000, 16'h4000, 16'h0000, 1'b0);
      send_beat(16'h1234, 16'h0100, 16'hFF00, 1'b1);
      send_beat(16'hC000, 16'h2000, 16'h2000, 1'b1);
      for (int s = 0; s < 12; s++)
         send_beat(16'(s * 780), 16'h3000, 16'h0000, 1'b1);
      settle();

      // Configuration phases, extremes first, then random settings.
      for (int phase = 0; phase < 10; phase++) begin
         case (phase)
            0: begin
               write_reg(svpwm_pkg::CSR_TIME_GAIN, 18'd0);
               write_reg(svpwm_pkg::CSR_MAX_DUTY, 18'd1);
            end
            1: begin
               write_reg(svpwm_pkg::CSR_TIME_GAIN, 18'h3FFFF);
               write_reg(svpwm_pkg::CSR_MAX_DUTY, 18'hFFFF);
               write_reg(svpwm_pkg::CSR_POLE_PAIRS, 18'd1);
               write_reg(svpwm_pkg::CSR_ZERO_OFFSET, 18'hFFFF);
            end
            2: begin
               write_reg(svpwm_pkg::CSR_POLE_PAIRS, 18'd64);
               write_reg(svpwm_pkg::CSR_REVERSE_DIR, 18'd1);
               write_reg(svpwm_pkg::CSR_ZERO_OFFSET, 18'd0);
               write_reg(svpwm_pkg::CSR_TIME_GAIN, svpwm_pkg::RST_TIME_GAIN);
            end
            default: begin
               write_reg(svpwm_pkg::CSR_ZERO_OFFSET, 18'($urandom_range(0, 65535)));
               write_reg(svpwm_pkg::CSR_POLE_PAIRS, 18'($urandom_range(1, 64)));
               write_reg(svpwm_pkg::CSR_REVERSE_DIR, 18'($urandom_range(0, 1)));
               write_reg(svpwm_pkg::CSR_TIME_GAIN, 18'($urandom_range(0, 262143)));
               write_reg(svpwm_pkg::CSR_MAX_DUTY, 18'($urandom_range(1, 65535)));
            end
         endcase
         csr_we <= 1'b0;
         quiet_rsp = (phase % 3 == 2);
         for (int n = 0; n < 110; n++) begin
            burst = (phase % 3 == 1) || (n % 40 < 8);
            random_volts(vq, vd);
            send_beat(16'($urandom), vq, vd, burst);
         end
         settle();
      end

      if (fail_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end
endmodule
